// ===== sv/lag_pkg.sv =====
// Package for the life automaton grid: op codes, register widths and limits,
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package lag_pkg;

  localparam int OP_W  = 3;
  localparam int ROW_W = 6;
  localparam int COL_W = 6;
  localparam int GS_W  = 7;

  localparam int MAX_SIZE_DEF = 64;

  localparam logic [GS_W-1:0] GS_MIN   = 7'd3;
  localparam logic [GS_W-1:0] GS_RESET = 7'd64;
  localparam logic [GS_W-1:0] GS_TOP   = 7'd127;

  localparam logic [OP_W-1:0] OP_SET    = 3'd0;
  localparam logic [OP_W-1:0] OP_TOGGLE = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
  localparam logic [OP_W-1:0] OP_STEP   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  typedef struct packed {
    logic accept;    // capture request payload, reset counter and window
    logic clr_grid;  // drop every row
    logic cfg_wr;    // new grid size, drop every row
    logic cell_rd;   // read the addressed row
    logic cell_wr;   // write back the modified row on set or toggle, capture the result
    logic gen_step;  // one step of the generation sweep
    logic out_load;  // move result into output register
  } ctl_cmd_t;

  typedef struct packed {
    logic gen_last;  // final step of the sweep
  } ctl_sts_t;

endpackage

`default_nettype wire

// ===== sv/lag_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lag_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/lag_ctrl.sv =====
// Controller for the life automaton grid: request dispatch, sequencing of
// cell and generation operations, output register handshake.
// Depends on lag_pkg.
`default_nettype none

module lag_ctrl
  import lag_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output      logic            in_stall,
  input  wire logic [OP_W-1:0] in_op,
  output      logic            out_valid,
  input  wire logic            out_stall,
  input  wire logic            cfg_valid,
  output      logic            cfg_ready,
  output      ctl_cmd_t        cmd,
  input  wire ctl_sts_t        sts
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CELL_RD = 3'd1;
  localparam logic [2:0] ST_CELL_WR = 3'd2;
  localparam logic [2:0] ST_GEN     = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       idle;
  logic       take;

  assign idle      = (state_r == ST_IDLE);
  assign cfg_ready = idle;
  // config write has priority over a request in the same cycle
  assign in_stall  = !idle || cfg_valid;
  assign take      = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.cfg_wr    = cfg_valid && idle;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          cmd.accept = 1'b1;
          case (in_op)
            OP_SET, OP_TOGGLE, OP_READ: state_nxt = ST_CELL_RD;
            OP_STEP:                    state_nxt = ST_GEN;
            OP_CLEAR: begin
              cmd.clr_grid = 1'b1;
              state_nxt    = ST_DONE;
            end
            default:                    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_CELL_RD: begin
        cmd.cell_rd = 1'b1;
        state_nxt   = ST_CELL_WR;
      end
      ST_CELL_WR: begin
        cmd.cell_wr = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_GEN: begin
        cmd.gen_step = 1'b1;
        if (sts.gen_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lag_dpath.sv =====
// Datapath for the life automaton grid: grid RAM with per-row valid bits,
// grid size register, three-row window and B3/S23 row update, result register.
// Depends on lag_pkg and lag_ram.
`default_nettype none

module lag_dpath
  import lag_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ctl_cmd_t         cmd,
  output      ctl_sts_t         sts,
  input  wire logic [OP_W-1:0]  in_op,
  input  wire logic [ROW_W-1:0] in_row,
  input  wire logic [COL_W-1:0] in_col,
  input  wire logic             in_value,
  input  wire logic [GS_W-1:0]  cfg_grid_size,
  output      logic             out_cell_value
);

  localparam int AW    = $clog2(MAX_SIZE);
  localparam int CNT_W = $clog2(MAX_SIZE + 4);
  localparam logic [GS_W-1:0] GS_MAX  = (MAX_SIZE > 127) ? GS_TOP : GS_W'(MAX_SIZE);
  localparam logic [GS_W-1:0] GS_INIT = (GS_RESET > GS_MAX) ? GS_MAX : GS_RESET;

  logic [OP_W-1:0]     op_r;
  logic [ROW_W-1:0]    row_r;
  logic [COL_W-1:0]    col_r;
  logic                val_r;
  logic [GS_W-1:0]     gs_r, gs_nxt;
  logic [MAX_SIZE-1:0] vld_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [MAX_SIZE-1:0] win_prev_r, win_cur_r, win_nxt_r;
  logic                rin_r;
  logic                rvalid_r;
  logic                res_r;
  logic                out_cell_value_r;

  logic [CNT_W-1:0]    gsx;
  logic                rd_in, do_shift, wr_in;
  logic                in_grid;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [MAX_SIZE-1:0] ram_wdata, ram_rdata;
  logic [MAX_SIZE-1:0] rd_row, cell_row, gen_row, col_mask;
  logic [AW-1:0]       col_idx;
  logic                old_bit, new_bit;

  assign gsx      = CNT_W'(gs_r);
  assign rd_in    = cnt_r < gsx;
  assign do_shift = cnt_r != '0;
  // row cnt-3 is complete in the window
  assign wr_in    = (cnt_r >= CNT_W'(3)) && (cnt_r < gsx + CNT_W'(3));
  assign sts.gen_last = (cnt_r == gsx + CNT_W'(2));

  assign in_grid = ({1'b0, row_r} < gs_r) && ({1'b0, col_r} < gs_r);
  assign rd_row  = rvalid_r ? ram_rdata : '0;
  assign col_idx = AW'(col_r);
  assign old_bit = rd_row[col_idx];
  assign new_bit = (op_r == OP_SET) ? val_r : !old_bit;

  always_comb begin
    cell_row          = rd_row;
    cell_row[col_idx] = new_bit;
  end

  always_comb begin
    for (int j = 0; j < MAX_SIZE; j++) begin
      col_mask[j] = CNT_W'(j) < gsx;
    end
  end

  // B3/S23 on the middle row of the window; edges and unused columns are dead
  always_comb begin
    logic [MAX_SIZE+1:0] pp, pc, pn;
    logic [3:0]          nb;
    pp = {1'b0, win_prev_r, 1'b0};
    pc = {1'b0, win_cur_r, 1'b0};
    pn = {1'b0, win_nxt_r, 1'b0};
    gen_row = '0;
    for (int j = 0; j < MAX_SIZE; j++) begin
      nb = 4'(pp[j]) + 4'(pp[j+1]) + 4'(pp[j+2])
         + 4'(pc[j]) + 4'(pc[j+2])
         + 4'(pn[j]) + 4'(pn[j+1]) + 4'(pn[j+2]);
      gen_row[j] = col_mask[j] && ((nb == 4'd3) || (pc[j+1] && (nb == 4'd2)));
    end
  end

  assign ram_re    = cmd.cell_rd || (cmd.gen_step && rd_in);
  assign ram_raddr = cmd.cell_rd ? AW'(row_r) : AW'(cnt_r);
  assign ram_we    = (cmd.gen_step && wr_in)
                  || (cmd.cell_wr && in_grid && ((op_r == OP_SET) || (op_r == OP_TOGGLE)));
  assign ram_waddr = cmd.gen_step ? AW'(cnt_r - CNT_W'(3)) : AW'(row_r);
  assign ram_wdata = cmd.gen_step ? gen_row : cell_row;

  lag_ram #(
    .WIDTH (MAX_SIZE),
    .DEPTH (MAX_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    gs_nxt = cfg_grid_size;
    if (cfg_grid_size > GS_MAX) begin
      gs_nxt = GS_MAX;
    end else if (cfg_grid_size < GS_MIN) begin
      gs_nxt = GS_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r  <= GS_INIT;
      vld_r <= '0;
    end else begin
      if (cmd.cfg_wr) begin
        gs_r <= gs_nxt;
      end
      if (cmd.cfg_wr || cmd.clr_grid) begin
        vld_r <= '0;
      end else if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= in_op;
      row_r      <= in_row;
      col_r      <= in_col;
      val_r      <= in_value;
      cnt_r      <= '0;
      win_prev_r <= '0;
      win_cur_r  <= '0;
      win_nxt_r  <= '0;
      res_r      <= 1'b0;
    end
    if (ram_re) begin
      rvalid_r <= vld_r[ram_raddr];
    end
    if (cmd.gen_step) begin
      cnt_r <= cnt_r + CNT_W'(1);
      rin_r <= rd_in;
      if (do_shift) begin
        win_prev_r <= win_cur_r;
        win_cur_r  <= win_nxt_r;
        win_nxt_r  <= rin_r ? rd_row : '0;
      end
    end
    if (cmd.cell_wr) begin
      res_r <= in_grid && ((op_r == OP_READ) ? old_bit : new_bit);
    end
    if (cmd.out_load) begin
      out_cell_value_r <= res_r;
    end
  end

  assign out_cell_value = out_cell_value_r;

endmodule

`default_nettype wire

// ===== sv/life_automaton_grid.sv =====
// Life automaton grid (B3/S23, bounded, no wraparound): top level.
// Channels: request in (in_valid/in_stall, op,row,col,value), one result per
// request out (out_valid/out_stall, cell_value), and a grid size write port
// (cfg_valid/cfg_ready, cfg_grid_size) that also clears the grid.
// Sequence: set, toggle and read read the addressed row, and set and toggle
// write it back, before the result is loaded; clear and unused ops go
// straight to loading the result; next generation runs a row sweep over the
// simple dual-port grid RAM (up to one row read and one row written per step,
// three rows buffered). The next request can be taken in the cycle after the
// result is loaded.
// One request is worked on at a time; in_stall is high from acceptance until
// the result moves into the output register, and while cfg_valid is high.
// A result waiting under out_stall does not block the next request, but
// that request's result holds in the block until the output register frees.
// Reset clears the grid at once (per-row valid bits) and sets grid_size to 64,
// or to MAX_SIZE when that is smaller.
// Depends on lag_pkg, lag_ctrl, lag_dpath and lag_ram.
`default_nettype none

module life_automaton_grid
  import lag_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire logic [OP_W-1:0]  in_op,
  input  wire logic [ROW_W-1:0] in_row,
  input  wire logic [COL_W-1:0] in_col,
  input  wire logic             in_value,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      logic             out_cell_value,
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [GS_W-1:0]  cfg_grid_size
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  lag_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  lag_dpath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_op),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_value       (in_value),
    .cfg_grid_size  (cfg_grid_size),
    .out_cell_value (out_cell_value)
  );

endmodule

`default_nettype wire
